[rtl/core/assert_macros.svh]
// Assertion macros for the checker module b64_checker.
// Depends on nothing; the using scope must declare clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/b64_pkg.sv]
// Shared types, codes and alphabet functions for the Base64 stream codec.
// Depends on nothing.
package b64_pkg;

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_FINISH  = 1'b1;
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  localparam logic [7:0] PAD_CHAR = 8'h3d;
  localparam logic [7:0] SYM_PAD  = 8'hfe;
  localparam logic [7:0] SYM_BAD  = 8'hff;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] carried_bits;
    logic       padding_stop;
  } b64_state_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       invalid;
    logic       last;
  } b64_res_t;

  // What one word does: its results, how many, and the state it leaves.
  typedef struct packed {
    b64_state_t     state;
    logic [1:0]     count;
    b64_res_t [2:0] res;
  } b64_step_t;

  function automatic logic [7:0] chr_of(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26)      return 8'(8'h41 + v8);
    else if (v < 6'd52) return 8'(8'h61 + v8 - 8'd26);
    else if (v < 6'd62) return 8'(8'h30 + v8 - 8'd52);
    else if (v == 6'd62) return 8'h2b;
    else                return 8'h2f;
  endfunction

  function automatic logic [7:0] sym_of(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a)      return 8'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7a) return 8'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) return 8'(c - 8'h30 + 8'd52);
    else if (c == 8'h2b)               return 8'd62;
    else if (c == 8'h2f)               return 8'd63;
    else if (c == PAD_CHAR)            return SYM_PAD;
    else                               return SYM_BAD;
  endfunction

endpackage

[rtl/core/b64_in_if.sv]
// Input channel of the Base64 codec: one byte or character per word.
// Depends on nothing.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink (input valid, input operation, input data_in, output ready);
endinterface

[rtl/core/b64_out_if.sv]
// Result channel of the Base64 codec: one character or byte per word.
// Depends on nothing.
interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       invalid;
  logic       last;

  modport source (output valid, output data_out, output invalid, output last, input ready);
  modport sink (input valid, input data_out, input invalid, input last, output ready);
endinterface

[rtl/core/b64_cfg_if.sv]
// Configuration write channel of the Base64 codec: the direction register.
// Depends on nothing.
interface b64_cfg_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink (input valid, input direction, output ready);
endinterface

[rtl/core/b64_step.sv]
// Combinational step: one word plus codec state gives results and next state.
// Depends on b64_pkg.
module b64_step import b64_pkg::*; (
  input  logic       direction,
  input  logic       operation,
  input  logic [7:0] data_in,
  input  b64_state_t state,
  output b64_step_t  step
);

  logic [7:0] b;
  logic [7:0] d;
  logic [7:0] cb;
  logic [1:0] cnt;
  b64_res_t [2:0] res;
  b64_state_t nst;

  assign b  = data_in;
  assign cb = state.carried_bits;
  assign d  = sym_of(data_in);

  always_comb begin
    nst = state;
    cnt = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end

    if (operation == OP_FINISH) begin
      if (direction == DIR_ENCODE) begin
        if (state.phase == PH_1 || state.phase == PH_2) begin
          res[0].data_out = chr_of(cb[5:0]);
          res[1].data_out = PAD_CHAR;
          res[2].data_out = PAD_CHAR;
          cnt = (state.phase == PH_1) ? 2'd3 : 2'd2;
        end
      end
      nst = '0;
    end else if (direction == DIR_ENCODE) begin
      case (state.phase)
        PH_1: begin
          res[0].data_out  = chr_of(cb[5:0] | {2'b00, b[7:4]});
          nst.carried_bits = {2'b00, b[3:0], 2'b00};
          nst.phase        = PH_2;
          cnt              = 2'd1;
        end
        PH_2: begin
          res[0].data_out  = chr_of(cb[5:0] | {4'b0000, b[7:6]});
          res[1].data_out  = chr_of(b[5:0]);
          nst.carried_bits = '0;
          nst.phase        = PH_0;
          cnt              = 2'd2;
        end
        default: begin
          // phase 3 only after a mid-message direction change: start afresh
          res[0].data_out  = chr_of(b[7:2]);
          nst.carried_bits = {2'b00, b[1:0], 4'b0000};
          nst.phase        = PH_1;
          cnt              = 2'd1;
        end
      endcase
    end else if (!state.padding_stop) begin
      if (d == SYM_PAD && (state.phase == PH_2 || state.phase == PH_3)) begin
        nst.padding_stop = 1'b1;
      end else if (d[7]) begin
        res[0].invalid = 1'b1;
        cnt            = 2'd1;
      end else begin
        case (state.phase)
          PH_0: begin
            nst.carried_bits = {d[5:0], 2'b00};
            nst.phase        = PH_1;
          end
          PH_1: begin
            res[0].data_out  = cb | {6'b000000, d[5:4]};
            nst.carried_bits = {d[3:0], 4'b0000};
            nst.phase        = PH_2;
            cnt              = 2'd1;
          end
          PH_2: begin
            res[0].data_out  = cb | {4'b0000, d[5:2]};
            nst.carried_bits = {d[1:0], 6'b000000};
            nst.phase        = PH_3;
            cnt              = 2'd1;
          end
          default: begin
            res[0].data_out  = cb | {2'b00, d[5:0]};
            nst.carried_bits = '0;
            nst.phase        = PH_0;
            cnt              = 2'd1;
          end
        endcase
      end
    end

    case (cnt)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      2'd3:    res[2].last = 1'b1;
      default: ;
    endcase
  end

  assign step.state = nst;
  assign step.count = cnt;
  assign step.res   = res;

endmodule

[rtl/core/b64_result_buf.sv]
// Result buffer: holds up to three results of one word, drains one per cycle while the output is ready.
// Depends on b64_pkg and b64_out_if.
module b64_result_buf import b64_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  b64_step_t        step,
  output logic             free,
  b64_out_if.source        out_chan
);

  logic [1:0]     cnt_r, cnt_nxt;
  b64_res_t [2:0] res_r, res_nxt;
  logic           pop;

  assign pop  = out_chan.valid && out_chan.ready;
  // room for a new set once the buffer is empty or its final word leaves now
  assign free = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  assign out_chan.valid    = (cnt_r != 2'd0);
  assign out_chan.data_out = res_r[0].data_out;
  assign out_chan.invalid  = res_r[0].invalid;
  assign out_chan.last     = res_r[0].last;

  always_comb begin
    cnt_nxt = cnt_r;
    res_nxt = res_r;
    if (load) begin
      cnt_nxt = step.count;
      res_nxt = step.res;
    end else if (pop) begin
      cnt_nxt    = 2'(cnt_r - 2'd1);
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

[rtl/core/base64_stream_codec.sv]
// Streaming Base64 codec, standard alphabet (A-Z a-z 0-9 + /) with '=' padding.
// The cfg direction bit selects encode (0: bytes in, characters out) or decode
// (1: characters in, bytes out); write it only while the codec is idle. An input
// word with operation=1 finishes the message: in encode it flushes the carried
// bits as one character plus "==" or "=", in decode it drops an unfinished
// group and clears a padding stop. Every word that produces results marks its
// final result with last; a bad decode character gives one word with invalid=1
// and data 0 and leaves the decoder state alone. Words causing no result
// (first character of a group, in-place padding, words after padding) are
// swallowed silently. Timing: an accepted word waits in the input register and
// moves into the result buffer once it has room, and the buffer then offers its
// results. A word yielding zero or one result is taken every cycle while the
// output is ready; an encode byte that completes a group yields two results and
// a finish flush two or three, which the single-wide result buffer drains one
// word per cycle while the output is ready; the next word waits meanwhile. While
// a result waits at the output, the input register takes one more word and then
// holds in_chan.ready low until the buffer is empty or its final word leaves.
module base64_stream_codec import b64_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  b64_in_if.sink    in_chan,
  b64_out_if.source out_chan,
  b64_cfg_if.sink   cfg_chan
);

  // configuration
  logic dir_r;

  // input register
  logic       in_vld_r;
  logic       in_op_r;
  logic [7:0] in_data_r;

  // codec state, updated when a word moves into the result buffer
  b64_state_t state_r;
  b64_step_t  step;
  logic       buf_free;
  logic       advance;

  assign cfg_chan.ready = 1'b1;

  assign advance       = in_vld_r && buf_free;
  assign in_chan.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= DIR_ENCODE;
      in_vld_r <= 1'b0;
      state_r  <= '0;
    end else begin
      if (cfg_chan.valid) begin
        dir_r <= cfg_chan.direction;
      end
      if (in_chan.ready) begin
        in_vld_r <= in_chan.valid;
      end
      if (advance) begin
        state_r <= step.state;
      end
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_op_r   <= in_chan.operation;
      in_data_r <= in_chan.data_in;
    end
  end

  b64_step u_step (
    .direction (dir_r),
    .operation (in_op_r),
    .data_in   (in_data_r),
    .state     (state_r),
    .step      (step)
  );

  b64_result_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .step     (step),
    .free     (buf_free),
    .out_chan (out_chan)
  );

endmodule

[rtl/core/b64_checker.sv]
// Port-level checks on the Base64 codec and their bind to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module b64_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data,
  input logic       out_invalid,
  input logic       out_last
);

  // no result may appear straight out of reset
  `CHK_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result valid after reset")

  // a bad character is a single, empty result
  `CHK_ASSERT(a_inv_shape, out_valid && out_invalid |-> out_last && out_data == 8'h00, "invalid result malformed")

  // results of one word leave without gaps
  `CHK_ASSERT(a_burst, out_valid && out_ready && !out_last |=> out_valid, "gap inside a result burst")

  // a stalled result holds
  `CHK_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last), "stalled result changed")

endmodule

bind base64_stream_codec b64_checker u_b64_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_data    (out_chan.data_out),
  .out_invalid (out_chan.invalid),
  .out_last    (out_chan.last)
);

[tb/tb.sv]
// Self-checking testbench for base64_stream_codec: a directed table, then random messages.
// Depends on b64_pkg, the three channel interfaces (b64_in_if, b64_out_if, b64_cfg_if)
// and the codec RTL.
module tb import b64_pkg::*;;

  localparam int RAND_WORDS     = 450;
  localparam int SETTLE_CYCLES  = 6;     // input reg + result buffer, with margin
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all

  // Alphabet as a byte table; entry 0 is the leftmost character.
  localparam logic [0:63][7:0] B64_ABC =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // One directed step: a word, or a direction write. A typed row carries
  // its result inline (zero or one word) instead of using the predictor.
  typedef struct {
    row_kind_t kind;
    logic      op;
    logic [7:0] val;
    bit        typed;
    int        n;
    b64_res_t  res;
  } stim_row_t;

  // Per-word note handed from the driver to the monitor.
  typedef struct {
    bit       typed;
    int       n;
    b64_res_t res;
  } word_note_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  b64_in_if  in_chan ();
  b64_out_if out_chan ();
  b64_cfg_if cfg_chan ();

  base64_stream_codec u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Predicted codec state; matches the post-reset values.
  logic       cur_dir   = DIR_ENCODE;
  logic [1:0] cur_phase = PH_0;
  logic [7:0] cur_carry = 8'h00;
  logic       cur_stop  = 1'b0;

  b64_res_t   step_out[$];         // results of the word just predicted
  b64_res_t   awaited_results[$];  // results the codec still owes us
  word_note_t word_notes[$];
  stim_row_t  stim_table[$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  in_burst = 1'b0;
  logic drv_dir = DIR_ENCODE;

  function automatic b64_res_t mk_res(input logic [7:0] d, input logic inv);
    b64_res_t r;
    r.data_out = d;
    r.invalid  = inv;
    r.last     = 1'b0;
    return r;
  endfunction

  // Linear search of the table: {found, sextet}.
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (B64_ABC[6'(i)] == c) return {1'b1, 6'(i)};
    end
    return 7'd0;
  endfunction

  // Advance the predicted state by one word and fill step_out.
  function automatic void codec_step(input logic op, input logic [7:0] din);
    logic [7:0] t;
    logic [6:0] s;
    step_out.delete();
    if (op == OP_FINISH) begin
      // Encode flushes the carry plus padding; decode just drops the group.
      if (cur_dir == DIR_ENCODE && (cur_phase == PH_1 || cur_phase == PH_2)) begin
        step_out.push_back(mk_res(B64_ABC[cur_carry[5:0]], 1'b0));
        step_out.push_back(mk_res(PAD_CHAR, 1'b0));
        if (cur_phase == PH_1) step_out.push_back(mk_res(PAD_CHAR, 1'b0));
      end
      cur_phase = PH_0;
      cur_carry = 8'h00;
      cur_stop  = 1'b0;
    end else if (cur_dir == DIR_ENCODE) begin
      case (cur_phase)
        PH_1: begin
          t = cur_carry | {4'b0, din[7:4]};
          step_out.push_back(mk_res(B64_ABC[t[5:0]], 1'b0));
          cur_carry = {2'b00, din[3:0], 2'b00};
          cur_phase = PH_2;
        end
        PH_2: begin
          t = cur_carry | {6'b0, din[7:6]};
          step_out.push_back(mk_res(B64_ABC[t[5:0]], 1'b0));
          step_out.push_back(mk_res(B64_ABC[din[5:0]], 1'b0));
          cur_carry = 8'h00;
          cur_phase = PH_0;
        end
        default: begin
          // phase 3 left over from decode counts as a fresh group
          step_out.push_back(mk_res(B64_ABC[din[7:2]], 1'b0));
          cur_carry = {2'b00, din[1:0], 4'b0000};
          cur_phase = PH_1;
        end
      endcase
    end else if (!cur_stop) begin
      s = char_sextet(din);
      if (din == PAD_CHAR && (cur_phase == PH_2 || cur_phase == PH_3)) begin
        cur_stop = 1'b1;
      end else if (!s[6]) begin
        // bad character or early padding: flag it, keep state
        step_out.push_back(mk_res(8'h00, 1'b1));
      end else begin
        case (cur_phase)
          PH_0: begin
            cur_carry = {s[5:0], 2'b00};
            cur_phase = PH_1;
          end
          PH_1: begin
            step_out.push_back(mk_res(cur_carry | {6'b0, s[5:4]}, 1'b0));
            cur_carry = {s[3:0], 4'b0000};
            cur_phase = PH_2;
          end
          PH_2: begin
            step_out.push_back(mk_res(cur_carry | {4'b0, s[5:2]}, 1'b0));
            cur_carry = {s[1:0], 6'b000000};
            cur_phase = PH_3;
          end
          default: begin
            step_out.push_back(mk_res(cur_carry | {2'b0, s[5:0]}, 1'b0));
            cur_carry = 8'h00;
            cur_phase = PH_0;
          end
        endcase
      end
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  // Monitor: checks result words, tracks direction writes, predicts
  // every accepted input word. All sampled on the rising edge.
  always @(posedge clk) begin
    b64_res_t   want;
    word_note_t note;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result word: data_out=%02h invalid=%0b last=%0b",
                 out_chan.data_out, out_chan.invalid, out_chan.last);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_chan.data_out !== want.data_out) begin
            $error("data_out: expected %02h, got %02h", want.data_out, out_chan.data_out);
            fail_count++;
          end
          if (out_chan.invalid !== want.invalid) begin
            $error("invalid: expected %0b, got %0b", want.invalid, out_chan.invalid);
            fail_count++;
          end
          if (out_chan.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_chan.last);
            fail_count++;
          end
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) cur_dir = cfg_chan.direction;
      if (in_chan.valid && in_chan.ready) begin
        note = (word_notes.size() != 0) ? word_notes.pop_front() : '{0, 0, '0};
        codec_step(in_chan.operation, in_chan.data_in);
        if (note.typed) begin
          // hand-written result wins; predictor state still moves on
          if (note.n == 1) awaited_results.push_back(note.res);
        end else begin
          foreach (step_out[i]) awaited_results.push_back(step_out[i]);
        end
      end
    end
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || (cfg_chan.valid && cfg_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("base64_stream_codec regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each word, with stretches of back-to-back acceptance.
  initial begin
    int stall;
    int burst_left;
    burst_left = 0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (burst_left > 0) begin
        burst_left--;
        stall = 0;
      end else begin
        if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 30);
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  task automatic send_word(input logic op, input logic [7:0] data, input bit typed,
                           input int tn, input b64_res_t tres);
    int gap;
    word_note_t note;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed = typed;
    note.n     = tn;
    note.res   = tres;
    word_notes.push_back(note);
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.data_in   <= data;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Direction is only rewritten once the codec has drained.
  task automatic set_direction(input logic d);
    int gap;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    // words with no result may still sit in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
    gap = $urandom_range(0, 11);
    repeat (gap) @(posedge clk);
    cfg_chan.valid     <= 1'b1;
    cfg_chan.direction <= d;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    drv_dir = d;
  endtask

  task automatic add_row(input row_kind_t kind, input logic op, input logic [7:0] val,
                         input bit typed, input int n, input b64_res_t res);
    stim_row_t r;
    r.kind  = kind;
    r.op    = op;
    r.val   = val;
    r.typed = typed;
    r.n     = n;
    r.res   = res;
    stim_table.push_back(r);
  endtask

  initial begin
    b64_res_t bad_word;
    b64_res_t first_a;
    int rand_count;
    int len;
    int groups;
    int pad;
    int kind;

    in_chan.valid      <= 1'b0;
    in_chan.operation  <= OP_DATA;
    in_chan.data_in    <= 8'h00;
    cfg_chan.valid     <= 1'b0;
    cfg_chan.direction <= DIR_ENCODE;

    bad_word = mk_res(8'h00, 1'b1);
    bad_word.last = 1'b1;
    first_a = mk_res("A", 1'b0);
    first_a.last = 1'b1;

    // Encode straight out of reset: byte extremes, all three flush shapes.
    add_row(ROW_WORD, OP_DATA,   8'h00, 1, 1, first_a);
    add_row(ROW_WORD, OP_DATA,   8'hff, 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   8'hff, 0, 0, '0);
    add_row(ROW_WORD, OP_FINISH, 8'h00, 1, 0, '0);   // phase 0: nothing to flush
    add_row(ROW_WORD, OP_DATA,   8'h4d, 0, 0, '0);
    add_row(ROW_WORD, OP_FINISH, 8'hff, 0, 0, '0);   // char + "=="
    add_row(ROW_WORD, OP_DATA,   8'h80, 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   8'h7f, 0, 0, '0);
    add_row(ROW_WORD, OP_FINISH, 8'h00, 0, 0, '0);   // char + "="
    add_row(ROW_WORD, OP_DATA,   8'h80, 0, 0, '0);   // leave a group open
    // Decode mid-message: bad char, early pad, then pad in phase 3.
    add_row(ROW_CFG,  OP_DATA,   {7'b0, DIR_DECODE}, 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   8'h00, 1, 1, bad_word);
    add_row(ROW_WORD, OP_DATA,   PAD_CHAR, 1, 1, bad_word);
    add_row(ROW_WORD, OP_DATA,   "z", 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   "+", 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   PAD_CHAR, 1, 0, '0);
    add_row(ROW_WORD, OP_DATA,   8'hff, 1, 0, '0);   // dropped while stopped
    add_row(ROW_WORD, OP_DATA,   "A", 1, 0, '0);
    add_row(ROW_WORD, OP_FINISH, 8'h00, 1, 0, '0);
    add_row(ROW_WORD, OP_DATA,   "9", 1, 0, '0);
    add_row(ROW_WORD, OP_DATA,   "0", 0, 0, '0);
    // Encode with a stale 8-bit decode carry in phase 2.
    add_row(ROW_CFG,  OP_DATA,   {7'b0, DIR_ENCODE}, 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   8'h3c, 0, 0, '0);
    add_row(ROW_CFG,  OP_DATA,   {7'b0, DIR_DECODE}, 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   "Q", 1, 0, '0);
    add_row(ROW_WORD, OP_DATA,   "/", 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   "5", 0, 0, '0);
    // Encode entered in phase 3.
    add_row(ROW_CFG,  OP_DATA,   {7'b0, DIR_ENCODE}, 0, 0, '0);
    add_row(ROW_WORD, OP_DATA,   8'ha5, 0, 0, '0);
    add_row(ROW_WORD, OP_FINISH, 8'h00, 0, 0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) set_direction(stim_table[i].val[0]);
      else send_word(stim_table[i].op, stim_table[i].val, stim_table[i].typed,
                     stim_table[i].n, stim_table[i].res);
    end

    // Random messages, mostly well formed, some noise, some left open
    // across a direction change.
    rand_count = 0;
    while (rand_count < RAND_WORDS) begin
      if ($urandom_range(0, 2) == 0 || $urandom_range(0, 7) == 0)
        set_direction(($urandom_range(0, 1) == 1) ? DIR_DECODE : DIR_ENCODE);
      in_burst = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (drv_dir == DIR_ENCODE) begin
        len = (kind < 8) ? $urandom_range(0, 8) : $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          // noise mixes finish words into the byte stream
          if (kind >= 8 && $urandom_range(0, 3) == 0)
            send_word(OP_FINISH, 8'($urandom_range(0, 255)), 0, 0, '0);
          else
            send_word(OP_DATA, 8'($urandom_range(0, 255)), 0, 0, '0);
          rand_count++;
        end
      end else if (kind < 7) begin
        // well-formed groups, last one optionally padded
        groups = $urandom_range(1, 3);
        for (int g = 0; g < groups; g++) begin
          pad = (g == groups - 1) ? $urandom_range(0, 2) : 0;
          for (int k = 0; k < 4 - pad; k++) begin
            send_word(OP_DATA, B64_ABC[6'($urandom_range(0, 63))], 0, 0, '0);
            rand_count++;
          end
          for (int k = 0; k < pad; k++) begin
            send_word(OP_DATA, PAD_CHAR, 0, 0, '0);
            rand_count++;
          end
          // trailing junk after padding is swallowed
          if (pad > 0 && $urandom_range(0, 2) == 0) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
              send_word(OP_DATA, 8'($urandom_range(0, 255)), 0, 0, '0);
              rand_count++;
            end
          end
        end
      end else begin
        // noise: raw bytes, valid chars, stray pads, partial groups
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 3))
            0:       send_word(OP_DATA, PAD_CHAR, 0, 0, '0);
            1:       send_word(OP_DATA, B64_ABC[6'($urandom_range(0, 63))], 0, 0, '0);
            default: send_word(OP_DATA, 8'($urandom_range(0, 255)), 0, 0, '0);
          endcase
          rand_count++;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        send_word(OP_FINISH, 8'($urandom_range(0, 255)), 0, 0, '0);
        rand_count++;
      end
    end

    in_chan.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d result words never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("base64_stream_codec regression: pass");
    end else begin
      $display("base64_stream_codec regression: fail");
    end
    $finish;
  end

endmodule
